[design/ssr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the stream search and replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int BYTE_W = 8;
	localparam int CNT_W  = 4;
	localparam int CFG_W  = 64;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_PATTERN      = 2'd0;
	localparam logic [IDX_W-1:0] REG_PATTERN_LEN  = 2'd1;
	localparam logic [IDX_W-1:0] REG_REPLACE      = 2'd2;
	localparam logic [IDX_W-1:0] REG_REPLACE_LEN  = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic              end_of_text;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_present;
		logic              string_done;
		logic              run_last;
	} out_t;

	typedef struct packed {
		logic ok;    // held window is a prefix of the pattern
		logic full;  // held count equals the pattern length
	} match_t;

	typedef struct packed {
		logic can_push;
		logic fin_ok;
		logic pend_v;
	} ostat_t;

endpackage

[design/ssr_match_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_match_unit
// Compares the held window against the pattern prefix of the same length.
// ----------------------------------------------------------------------------
module ssr_match_unit import ssr_pkg::*; #(
	parameter int MAX_PATTERN = 8
) (
	input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] window,
	input  logic [CNT_W-1:0]                   count,
	input  logic [CFG_W-1:0]                   pattern,
	input  logic [CNT_W-1:0]                   pattern_len,
	output match_t                             result
);

	logic [MAX_PATTERN-1:0] hit;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
		assign hit[j] = (CNT_W'(j) >= count) ||
			(window[j] == pattern[BYTE_W*j +: BYTE_W]);
	end

	assign result.ok   = (count <= pattern_len) && (&hit);
	assign result.full = (count == pattern_len);

endmodule

[design/ssr_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_out_stage
// Pending result plus output register; tags the last result of an item.
// ----------------------------------------------------------------------------
module ssr_out_stage import ssr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  out_t   push_item,
	input  logic   finish,
	output ostat_t status,
	output logic   out_valid,
	input  logic   out_ready,
	output out_t   out_item
);

	logic out_v_q;
	logic pend_v_q;
	out_t pend_q;
	out_t out_q;
	logic adv;
	logic do_push;
	logic do_fin;
	logic load_out;
	out_t load_item;

	assign adv      = !out_v_q || out_ready;
	assign do_push  = push && (!pend_v_q || adv);
	assign do_fin   = finish && (!pend_v_q || adv);
	assign load_out = pend_v_q && (do_push || do_fin);

	assign status.can_push = !pend_v_q || adv;
	assign status.fin_ok   = !pend_v_q || adv;
	assign status.pend_v   = pend_v_q;

	always_comb begin
		load_item          = pend_q;
		load_item.run_last = do_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (do_push) begin
				pend_v_q <= 1'b1;
			end else if (do_fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= load_item;
		end
		if (do_push) begin
			pend_q <= push_item;
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;

endmodule

[design/stream_search_replace.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_search_replace
// Streaming search and replace: every leftmost, non-overlapping pattern
// occurrence in a byte stream is replaced, partial matches are held.
// ----------------------------------------------------------------------------
// Flow: a byte is taken at idle; held bytes are released until the window
//   matches the pattern head, a full match sends the replacement bytes, and
//   the final byte flushes held bytes and sends an end marker; then the item
//   closes. A new byte is taken only at idle. The single shared window
//   compare gives one result per cycle unless the output stage stalls.
// Reset: arst_n clears held count, sequencer and output valid; config resets
//   to an empty replacement of a one-byte zero pattern.
// ----------------------------------------------------------------------------
module stream_search_replace import ssr_pkg::*; #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_item
);

	localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam logic [CNT_W-1:0] PMAX = CNT_W'(MAX_PATTERN);
	localparam logic [CNT_W-1:0] RMAX = CNT_W'(MAX_REPLACEMENT);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MATCH = 3'd1;
	localparam logic [2:0] S_REPL  = 3'd2;
	localparam logic [2:0] S_FLUSH = 3'd3;
	localparam logic [2:0] S_MARK  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [CFG_W-1:0] pat_q;
	logic [CNT_W-1:0] plen_q;
	logic [CFG_W-1:0] repl_q;
	logic [CNT_W-1:0] rlen_q;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] r_q;
	logic             eot_q;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] hold_q;

	logic [CNT_W-1:0] plen;
	logic [CNT_W-1:0] rlen;
	match_t           mres;
	ostat_t           ost;
	logic             emit;
	logic             step;
	logic             finish;
	out_t             emit_item;
	logic             take;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			plen_q <= CNT_W'(1);
			repl_q <= '0;
			rlen_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN:     pat_q  <= cfg_data;
				REG_PATTERN_LEN: plen_q <= cfg_data[CNT_W-1:0];
				REG_REPLACE:     repl_q <= cfg_data;
				REG_REPLACE_LEN: rlen_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (plen_q == '0) begin
			plen = CNT_W'(1);
		end else if (plen_q > PMAX) begin
			plen = PMAX;
		end else begin
			plen = plen_q;
		end
		rlen = (rlen_q > RMAX) ? RMAX : rlen_q;
	end

	ssr_match_unit #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_match (
		.window      (hold_q),
		.count       (cnt_q),
		.pattern     (pat_q),
		.pattern_len (plen),
		.result      (mres)
	);

	always_comb begin
		emit      = 1'b0;
		finish    = 1'b0;
		emit_item = '0;
		unique case (state_q)
			S_MATCH: begin
				if (!mres.ok) begin
					emit                   = 1'b1;
					emit_item.out_byte     = hold_q[0];
					emit_item.byte_present = 1'b1;
				end
			end
			S_REPL: begin
				if (r_q != rlen) begin
					emit                   = 1'b1;
					emit_item.out_byte     = repl_q[{r_q[2:0], 3'b000} +: BYTE_W];
					emit_item.byte_present = 1'b1;
				end
			end
			S_FLUSH: begin
				if (cnt_q != '0) begin
					emit                   = 1'b1;
					emit_item.out_byte     = hold_q[0];
					emit_item.byte_present = 1'b1;
				end
			end
			S_MARK: begin
				emit                  = 1'b1;
				emit_item.string_done = 1'b1;
			end
			S_FIN: begin
				finish = 1'b1;
			end
			default: ;
		endcase
	end

	assign step     = emit && ost.can_push;
	assign in_ready = (state_q == S_IDLE);
	assign take     = in_valid && in_ready;

	// held window: append on transfer, shift out front byte on release
	always_ff @(posedge clk) begin
		if (take) begin
			hold_q[cnt_q[IW-1:0]] <= in_item.text_byte;
		end else if (step && (state_q == S_MATCH || state_q == S_FLUSH)) begin
			for (int j = 0; j < MAX_PATTERN - 1; j++) begin
				hold_q[j] <= hold_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			r_q     <= '0;
			eot_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cnt_q   <= CNT_W'(cnt_q + 1'b1);
						eot_q   <= in_item.end_of_text;
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					if (mres.ok) begin
						if (mres.full) begin
							cnt_q   <= '0;
							r_q     <= '0;
							state_q <= S_REPL;
						end else begin
							state_q <= eot_q ? S_FLUSH : S_FIN;
						end
					end else if (step) begin
						cnt_q <= CNT_W'(cnt_q - 1'b1);
					end
				end
				S_REPL: begin
					if (r_q == rlen) begin
						state_q <= eot_q ? S_FLUSH : S_FIN;
					end else if (step) begin
						r_q <= CNT_W'(r_q + 1'b1);
					end
				end
				S_FLUSH: begin
					if (cnt_q == '0) begin
						state_q <= S_MARK;
					end else if (step) begin
						cnt_q <= CNT_W'(cnt_q - 1'b1);
					end
				end
				S_MARK: begin
					if (step) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (ost.fin_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ssr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_item (emit_item),
		.finish    (finish),
		.status    (ost),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q <= PMAX - CNT_W'(1)))
		else $error("held count too large at idle");

	a_take_match: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_MATCH))
		else $error("transfer did not start compare");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ost.pend_v)
		else $error("pending result left at idle");

	a_repl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REPL) |-> (r_q <= RMAX))
		else $error("replacement index out of range");

endmodule

[tb/sv/ssr_rewrite_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_rewrite_check
// Watches the rule writes and both streams of stream_search_replace. Each
// byte transfer is run through a local copy of the search and replace
// rules, and the rewritten bytes, flush bytes and end markers it yields are
// queued and compared field by field with the output transfers in order.
// ----------------------------------------------------------------------------
module ssr_rewrite_check import ssr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	input  logic             in_ready,
	input  in_t              in_item,
	input  logic             out_valid,
	input  logic             out_ready,
	input  out_t             out_item,
	output int               mismatches,
	output int               pending
);

	logic [CFG_W-1:0] pat_word;
	logic [CNT_W-1:0] pat_len;
	logic [CFG_W-1:0] rep_word;
	logic [CNT_W-1:0] rep_len;
	logic [7:0]       held [8];
	int               held_n;
	out_t             rewritten_q [$];

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	function automatic out_t text_result(input logic [7:0] b);
		out_t r;
		r = '0;
		r.out_byte     = b;
		r.byte_present = 1'b1;
		return r;
	endfunction

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic rewrite_byte(input in_t it);
		logic [7:0] win [9];
		out_t       burst [$];
		out_t       mark;
		int         plen, rlen, n, sh, len, j;
		bit         ok, found;
		plen = (pat_len == 0) ? 1 : ((pat_len > 8) ? 8 : int'(pat_len));
		rlen = (rep_len > 8) ? 8 : int'(rep_len);
		for (j = 0; j < held_n; j++)
			win[j] = held[j];
		win[held_n] = it.text_byte;
		n = held_n + 1;

		// shortest release that leaves a window still matching the pattern head
		sh = 0;
		len = 0;
		found = 1'b0;
		while (!found) begin
			len = n - sh;
			ok = (len <= plen);
			for (j = 0; j < len; j++)
				if (ok && win[sh + j] != pat_word[8 * j +: 8])
					ok = 1'b0;
			if (ok)
				found = 1'b1;
			else
				sh++;
		end

		for (j = 0; j < sh; j++)
			burst.push_back(text_result(win[j]));
		if (len == plen) begin
			for (j = 0; j < rlen; j++)
				burst.push_back(text_result(rep_word[8 * j +: 8]));
			held_n = 0;
		end else begin
			for (j = 0; j < len; j++)
				held[j] = win[sh + j];
			held_n = len;
		end

		if (it.end_of_text) begin
			for (j = 0; j < held_n; j++)
				burst.push_back(text_result(held[j]));
			held_n = 0;
			mark = '0;
			mark.string_done = 1'b1;
			burst.push_back(mark);
		end

		if (burst.size() > 0)
			burst[burst.size() - 1].run_last = 1'b1;
		for (j = 0; j < burst.size(); j++)
			rewritten_q.push_back(burst[j]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			pat_word = '0;
			pat_len  = 4'd1;
			rep_word = '0;
			rep_len  = '0;
			held_n   = 0;
			rewritten_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PATTERN:     pat_word = cfg_data;
					REG_PATTERN_LEN: pat_len  = cfg_data[CNT_W-1:0];
					REG_REPLACE:     rep_word = cfg_data;
					REG_REPLACE_LEN: rep_len  = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (rewritten_q.size() == 0) begin
					report("unexpected transfer, out_byte", out_item.out_byte, 8'h00);
				end else begin
					want = rewritten_q.pop_front();
					if (out_item.out_byte !== want.out_byte)
						report("out_byte", out_item.out_byte, want.out_byte);
					if (out_item.byte_present !== want.byte_present)
						report("byte_present", 8'(out_item.byte_present),
						       8'(want.byte_present));
					if (out_item.string_done !== want.string_done)
						report("string_done", 8'(out_item.string_done),
						       8'(want.string_done));
					if (out_item.run_last !== want.run_last)
						report("run_last", 8'(out_item.run_last), 8'(want.run_last));
				end
			end
			if (in_valid && in_ready)
				rewrite_byte(in_item);
			pending <= rewritten_q.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for stream_search_replace. Directed strings hit the
// reset rules, overlapping patterns, saturated lengths and a rule change
// inside a string; then random rule sets drive text built mostly from
// pattern pieces with random noise, under random sender and receiver gaps
// and one long receiver hold. Checking is done by ssr_rewrite_check.
// ----------------------------------------------------------------------------
module tb;
	import ssr_pkg::*;

	localparam int TEXT_ITEMS = 195;
	localparam int SETTLE     = 40;
	localparam int HOLD       = 300;
	localparam int LIMIT      = 2000;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = REG_PATTERN;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_item   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_item;
	int               mismatches;
	int               pending;

	logic [CFG_W-1:0] cur_pattern;
	int               cur_plen;
	logic [7:0]       alphabet [3];
	bit               tx_calm;
	bit               rx_calm;
	int               sent;
	int               hold_asked;
	int               hold_done;
	int               quiet;

	stream_search_replace u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	ssr_rewrite_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic set_rules(input logic [CFG_W-1:0] pat, input logic [3:0] plen,
				 input logic [CFG_W-1:0] rep, input logic [3:0] rlen);
		write_reg(REG_PATTERN, pat);
		write_reg(REG_PATTERN_LEN, {60'd0, plen});
		write_reg(REG_REPLACE, rep);
		write_reg(REG_REPLACE_LEN, {60'd0, rlen});
		cfg_we <= 1'b0;
		cur_pattern = pat;
		cur_plen = (plen == 0) ? 1 : ((plen > 8) ? 8 : int'(plen));
	endtask

	task automatic send(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{text_byte: b, end_of_text: last};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// drain all results, then let a byte with no output finish inside the block
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_rules();
		logic [CFG_W-1:0] pat;
		logic [3:0]       plen, rlen;
		int               j;
		for (j = 0; j < 3; j++)
			alphabet[j] = 8'($urandom_range(0, 255));
		pat = {$urandom, $urandom};
		for (j = 0; j < 8; j++)
			pat[8 * j +: 8] = alphabet[$urandom_range(0, 2)];
		case ($urandom_range(0, 11))
			0:       plen = 4'd0;
			1:       plen = 4'($urandom_range(9, 15));
			default: plen = 4'($urandom_range(1, 8));
		endcase
		rlen = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
						   : 4'($urandom_range(0, 8));
		set_rules(pat, plen, {$urandom, $urandom}, rlen);
	endtask

	// text mostly walks the pattern, with restarts and noise between
	task automatic send_string(input int len, input bit close);
		int         j, pos, roll;
		logic [7:0] b;
		pos = 0;
		for (j = 0; j < len; j++) begin
			roll = $urandom_range(0, 19);
			if (roll < 11) begin
				b = cur_pattern[8 * pos +: 8];
				pos = (pos + 1) % cur_plen;
			end else if (roll < 17) begin
				b = alphabet[$urandom_range(0, 2)];
				pos = 0;
			end else begin
				b = 8'($urandom_range(0, 255));
				pos = 0;
			end
			send(b, close && (j == len - 1));
		end
	endtask

	initial begin
		int i, phase;
		logic [7:0] aab [6];
		aab = '{8'h61, 8'h61, 8'h61, 8'h62, 8'h61, 8'h61};
		sent = 0;
		hold_asked = 0;
		tx_calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset rules: single zero byte deleted
		send(8'h00, 1'b0);
		send(8'hFF, 1'b1);
		wait_idle();

		// self-overlapping pattern, flush of a partial match at the end
		set_rules(64'h62_6161, 4'd3, 64'h5958, 4'd2);
		for (i = 0; i < 6; i++)
			send(aab[i], i == 5);
		wait_idle();

		// zero pattern length and oversized replacement length
		set_rules('1, 4'd0, '1, 4'd12);
		send(8'hFF, 1'b1);
		send(8'h7F, 1'b1);
		wait_idle();

		// oversized pattern length, seven bytes held across a rule change
		set_rules(64'h0807_0605_0403_0201, 4'd15, '0, 4'd0);
		for (i = 1; i <= 7; i++)
			send(i[7:0], 1'b0);
		wait_idle();
		set_rules(64'h5A, 4'd1, {$urandom, $urandom}, 4'd8);
		send(8'h5A, 1'b1);
		wait_idle();

		phase = 0;
		while (sent < TEXT_ITEMS) begin
			random_rules();
			tx_calm = (phase == 2) || ($urandom_range(0, 3) == 0);
			if (phase == 2)
				hold_asked++;
			repeat ($urandom_range(2, 4))
				send_string($urandom_range(1, 12), 1'b1);
			if ($urandom_range(0, 2) == 0)
				send_string($urandom_range(1, 6), 1'b0);
			wait_idle();
			phase++;
		end
		tx_calm = 1'b0;
		send_string($urandom_range(1, 3), 1'b1);
		wait_idle();

		if (mismatches == 0 && pending == 0)
			$display("stream_search_replace test passed");
		else
			$display("stream_search_replace test failed");
		$finish;
	end

	initial begin
		int stall;
		hold_done = 0;
		rx_calm = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_done != hold_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD) @(posedge clk);
				hold_done++;
			end
			stall = rx_calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= LIMIT) begin
			$display("stream_search_replace test failed");
			$finish;
		end
	end

	initial quiet = 0;

endmodule

[files.f]
design/ssr_pkg.sv
design/ssr_match_unit.sv
design/ssr_out_stage.sv
design/stream_search_replace.sv
tb/sv/ssr_rewrite_check.sv
tb/sv/tb.sv
